### hdl/bdp_pkg.sv
// Shared types and constants for the bfloat16 dot-product unit.
`default_nettype none
package bdp_pkg;

  typedef logic [31:0] fp32_t;
  typedef logic [15:0] bf16_t;

  localparam fp32_t CANON_NAN = 32'h7FC0_0000;
  localparam fp32_t FP32_ZERO = 32'h0000_0000;
  localparam logic [7:0] EXP_MAX = 8'hFF;

endpackage
`default_nettype wire

### hdl/bdp_mul.sv
// Combinational bfloat16 by bfloat16 multiplier giving a round-to-nearest-even fp32 product.
`default_nettype none
module bdp_mul (
  input  bdp_pkg::bf16_t a,
  input  bdp_pkg::bf16_t b,
  output bdp_pkg::fp32_t p
);
  import bdp_pkg::*;

  always_comb begin
    logic              sa, sb, sp;
    logic [7:0]        ea, eb;
    logic [6:0]        fa, fb;
    logic [7:0]        ma, mb;
    logic [8:0]        xa, xb;
    logic [9:0]        sumx;
    logic [15:0]       prod;
    logic [3:0]        lp;
    logic signed [11:0] bexp;
    logic signed [11:0] sh;
    logic [4:0]        rs;
    logic [47:0]       wide;
    logic [23:0]       frac;
    logic              g, st, rnd;
    logic [30:0]       mag;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    sa = a[15];
    sb = b[15];
    sp = sa ^ sb;
    ea = a[14:7];
    eb = b[14:7];
    fa = a[6:0];
    fb = b[6:0];
    a_nan  = (ea == EXP_MAX) && (fa != 7'd0);
    b_nan  = (eb == EXP_MAX) && (fb != 7'd0);
    a_inf  = (ea == EXP_MAX) && (fa == 7'd0);
    b_inf  = (eb == EXP_MAX) && (fb == 7'd0);
    a_zero = (ea == 8'd0) && (fa == 7'd0);
    b_zero = (eb == 8'd0) && (fb == 7'd0);
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    xa = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
    xb = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
    sumx = {1'b0, xa} + {1'b0, xb};
    prod = {8'd0, ma} * {8'd0, mb};
    lp = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (prod[i]) begin
        lp = i[3:0];
      end
    end
    bexp = $signed({8'd0, lp}) + $signed({2'b00, sumx}) - 12'sd141;
    sh = $signed({2'b00, sumx}) - 12'sd119;
    frac = 24'd0;
    g = 1'b0;
    st = 1'b0;
    rnd = 1'b0;
    rs = 5'd0;
    wide = 48'd0;
    mag = 31'd0;
    if (bexp >= 12'sd1) begin
      frac = {8'd0, prod} << (5'd23 - {1'b0, lp});
      mag = {bexp[7:0], frac[22:0]};
    end else begin
      if (sh >= 12'sd0) begin
        frac = {8'd0, prod} << sh[4:0];
      end else begin
        rs = (sh < -12'sd31) ? 5'd31 : 5'(-sh);
        wide = {prod, 32'd0} >> rs;
        frac = {8'd0, wide[47:32]};
        g = wide[31];
        st = |wide[30:0];
      end
      rnd = g & (st | frac[0]);
      mag = {8'd0, frac[22:0]} + {30'd0, rnd};
    end

    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      p = CANON_NAN;
    end else if (a_inf || b_inf) begin
      p = {sp, EXP_MAX, 23'd0};
    end else if (prod == 16'd0) begin
      p = {sp, 31'd0};
    end else if (bexp >= 12'sd255) begin
      p = {sp, EXP_MAX, 23'd0};
    end else begin
      p = {sp, mag};
    end
  end

endmodule
`default_nettype wire

### hdl/bdp_add.sv
// Combinational fp32 adder with round-to-nearest-even and a canonical NaN result.
`default_nettype none
module bdp_add (
  input  bdp_pkg::fp32_t a,
  input  bdp_pkg::fp32_t b,
  output bdp_pkg::fp32_t y
);
  import bdp_pkg::*;

  always_comb begin
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        swap, sl, ss, sub;
    logic [7:0]  el, es, xl, xs, d;
    logic [4:0]  dc, lz;
    logic [23:0] ml, ms;
    logic [26:0] mlx, msx, al, mask, dif, nm;
    logic [27:0] sum28;
    logic [7:0]  sh;
    logic [8:0]  ne;
    logic [7:0]  ef;
    logic        rnd;
    logic [30:0] mag;

    a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    swap = b[30:0] > a[30:0];
    sl = swap ? b[31] : a[31];
    ss = swap ? a[31] : b[31];
    el = swap ? b[30:23] : a[30:23];
    es = swap ? a[30:23] : b[30:23];
    ml = swap ? {(b[30:23] != 8'd0), b[22:0]} : {(a[30:23] != 8'd0), a[22:0]};
    ms = swap ? {(a[30:23] != 8'd0), a[22:0]} : {(b[30:23] != 8'd0), b[22:0]};
    xl = (el == 8'd0) ? 8'd1 : el;
    xs = (es == 8'd0) ? 8'd1 : es;
    d = xl - xs;
    dc = (d >= 8'd27) ? 5'd27 : d[4:0];
    sub = sl ^ ss;
    mlx = {ml, 3'b000};
    msx = {ms, 3'b000};
    mask = ~(27'h7FF_FFFF << dc);
    al = msx >> dc;
    al[0] = al[0] | (|(msx & mask));
    sum28 = 28'd0;
    dif = 27'd0;
    lz = 5'd0;
    sh = 8'd0;
    if (!sub) begin
      sum28 = {1'b0, mlx} + {1'b0, al};
      if (sum28[27]) begin
        nm = {sum28[27:2], sum28[1] | sum28[0]};
        ne = {1'b0, xl} + 9'd1;
      end else begin
        nm = sum28[26:0];
        ne = {1'b0, xl};
      end
    end else begin
      dif = mlx - al;
      for (int i = 0; i < 27; i++) begin
        if (dif[i]) begin
          lz = 5'(26 - i);
        end
      end
      sh = ({3'd0, lz} < (xl - 8'd1)) ? {3'd0, lz} : (xl - 8'd1);
      nm = dif << sh;
      ne = {1'b0, xl} - {1'b0, sh};
    end
    ef = nm[26] ? ne[7:0] : 8'd0;
    rnd = nm[2] & (nm[1] | nm[0] | nm[3]);
    mag = {ef, nm[25:3]} + {30'd0, rnd};

    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      y = CANON_NAN;
    end else if (a_inf) begin
      y = a;
    end else if (b_inf) begin
      y = b;
    end else if (sub && (dif == 27'd0)) begin
      y = FP32_ZERO;
    end else if (ne >= 9'd255) begin
      y = {sl, EXP_MAX, 23'd0};
    end else begin
      y = {sl, mag};
    end
  end

endmodule
`default_nettype wire

### hdl/bf16_dot_product_fp32_accumulate_unit.sv
// Top level of the bfloat16 dot-product unit with an fp32 accumulator.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  row_value, col_value, last
//   out      output     out_valid/out_stall result
//
// One transaction can be accepted every cycle while in_stall is low; a result appears once
// the last transaction of a run has passed the input register, product register and result
// register. The fp32 add into the accumulator register closes a loop that sets the rate.
// Reset clears the accumulator to +0 and empties the pipeline.
// A stalled result only holds back the pipeline once another last transaction reaches it.
`default_nettype none
module bf16_dot_product_fp32_accumulate_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire bdp_pkg::bf16_t row_value,
  input  wire bdp_pkg::bf16_t col_value,
  input  wire logic           last,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      bdp_pkg::bf16_t result
);
  import bdp_pkg::*;

  logic  s1_valid, s1_last;
  bf16_t s1_row, s1_col;
  logic  s2_valid, s2_last;
  fp32_t s2_prod;
  fp32_t prod, sum, accumulator;
  logic  out_free, s2_take, s2_ready;

  bdp_mul u_mul (.a(s1_row), .b(s1_col), .p(prod));
  bdp_add u_add (.a(accumulator), .b(s2_prod), .y(sum));

  assign out_free = !out_valid || !out_stall;
  assign s2_take  = s2_valid && (!s2_last || out_free);
  assign s2_ready = !s2_valid || s2_take;
  assign in_stall = s1_valid && !s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      accumulator <= FP32_ZERO;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        out_valid <= s2_take && s2_last;
      end
      if (s2_take) begin
        accumulator <= s2_last ? FP32_ZERO : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_row  <= row_value;
      s1_col  <= col_value;
      s1_last <= last;
    end
    if (s2_ready) begin
      s2_prod <= prod;
      s2_last <= s1_last;
    end
    if (s2_take && s2_last) begin
      result <= sum[31:16];
    end
  end

endmodule
`default_nettype wire
